/* hdl/vtx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtx_pkg
// Types, widths and constants shared by the vertex transform block.
// ----------------------------------------------------------------------------
package vtx_pkg;

    localparam int IO_BITS   = 32;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = (NUM_BITS + DIV_STEPS - 1) / DIV_STEPS;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

    // 1.0 in the working format, clipped when it does not fit
    localparam logic  ONE_OVF = (FRAC_BITS > WORD_BITS - 2);
    localparam word_t ONE_SAT = ONE_OVF ? WORD_MAX : word_t'(64'sd1 << FRAC_BITS);

    localparam logic [NUM_BITS-1:0] Q_POS_MAX =
        NUM_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic [NUM_BITS-1:0] Q_NEG_MAX =
        NUM_BITS'({1'b1, {(WORD_BITS-1){1'b0}}});

    typedef struct packed {
        logic                       opcode;
        logic [3:0]                 coeff_index;
        logic signed [IO_BITS-1:0]  coeff_value;
        logic signed [IO_BITS-1:0]  vx;
        logic signed [IO_BITS-1:0]  vy;
        logic signed [IO_BITS-1:0]  vz;
        logic signed [IO_BITS-1:0]  vw;
        logic                       normalize;
    } vtx_in_t;

    typedef struct packed {
        logic signed [IO_BITS-1:0]  rx;
        logic signed [IO_BITS-1:0]  ry;
        logic signed [IO_BITS-1:0]  rz;
        logic signed [IO_BITS-1:0]  rw;
        logic                       overflow;
        logic                       divide_by_zero;
    } vtx_out_t;

    // one divider lane: dividend/quotient shifter and partial remainder
    typedef struct packed {
        logic [NUM_BITS-1:0]  a;
        logic [WORD_BITS-1:0] rem;
        logic                 neg;
    } div_lane_t;

    // side info carried alongside the divider lanes
    typedef struct packed {
        logic                       norm;
        logic                       dz;
        logic                       ovf;
        logic [WORD_BITS-1:0]       den;
        logic [3:0][WORD_BITS-1:0]  r;
    } div_ctl_t;

endpackage

/* hdl/vertex_transform_4x4.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// 4x4 fixed-point matrix times vector with optional perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one transaction per
//   accepted edge. opcode load writes one column-major Q16.16 coefficient and
//   returns nothing; opcode transform returns one rsp transaction.
//   rsp channel (rsp_valid / rsp_stall / rsp) carries rx..rw, overflow and
//   divide_by_zero.
// Pipeline: 4 + DIV_STAGES + 1 register stages (29 at Q16.16: the divider is
//   a 48-bit restoring array, two quotient bits per stage).
// Throughput: one transaction per cycle unless rsp is held; loads and transforms mixed freely.
// Reset: all valid bits clear, matrix returns to identity.
// Stall: when rsp is held, the whole pipeline freezes in place and req_stall
//   rises in the same cycle; nothing is dropped or duplicated.
// A load takes effect for every transform accepted after it.
// ----------------------------------------------------------------------------
module vertex_transform_4x4
    import vtx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  vtx_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output vtx_out_t rsp
);

    // global advance: pipeline moves unless the output is held
    logic adv;
    logic req_acc;
    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;
    assign req_acc   = req_valid && adv;

    // ---------------- coefficient store ----------------
    word_t matrix_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                matrix_reg[i] <= (i[1:0] == i[3:2]) ? ONE_SAT : '0;
            end
        end
        else if (req_acc && req.opcode == OP_LOAD)
        begin
            matrix_reg[req.coeff_index] <= word_t'(req.coeff_value[WORD_BITS-1:0]);
        end
    end

    // ---------------- stage 1: input register ----------------
    logic  s1_valid_reg;
    word_t s1_v_reg [4];
    logic  s1_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= req_acc && (req.opcode == OP_XFORM);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_v_reg[0] <= word_t'(req.vx[WORD_BITS-1:0]);
            s1_v_reg[1] <= word_t'(req.vy[WORD_BITS-1:0]);
            s1_v_reg[2] <= word_t'(req.vz[WORD_BITS-1:0]);
            s1_v_reg[3] <= word_t'(req.vw[WORD_BITS-1:0]);
            s1_norm_reg <= req.normalize;
        end
    end

    // ---------------- stage 2: sixteen products ----------------
    // the matrix is read here; a load accepted on this same edge still
    // sees the old coefficients, which matches transaction order
    logic  s2_valid_reg;
    logic  s2_norm_reg;
    prod_t s2_prod_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_norm_reg <= s1_norm_reg;
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    // signed 32 x 32, full 64-bit product
                    s2_prod_reg[c*4 + r] <= s1_v_reg[c] * matrix_reg[c*4 + r];
                end
            end
        end
    end

    // ---------------- stage 3: pairwise sums ----------------
    logic s3_valid_reg;
    logic s3_norm_reg;
    sum_t s3_pair_reg [4][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_norm_reg <= s2_norm_reg;
            for (int r = 0; r < 4; r++)
            begin
                s3_pair_reg[r][0] <= sum_t'(s2_prod_reg[r]) + sum_t'(s2_prod_reg[4 + r]);
                s3_pair_reg[r][1] <= sum_t'(s2_prod_reg[8 + r]) + sum_t'(s2_prod_reg[12 + r]);
            end
        end
    end

    // ---------------- stage 4: final sum, floor shift, saturate ----------------
    // floor of the exact sum equals the sum of floors plus the carried fraction
    logic  s4_valid_reg;
    logic  s4_norm_reg;
    logic  s4_ovf_reg;
    word_t s4_r_reg [4];
    word_t s4_r_next [4];
    logic  s4_ovf_next;

    always_comb
    begin
        sum_t tot;
        sum_t sh;
        s4_ovf_next = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            tot = s3_pair_reg[r][0] + s3_pair_reg[r][1];
            sh  = tot >>> FRAC_BITS;
            if (sh > sum_t'(WORD_MAX))
            begin
                s4_r_next[r] = WORD_MAX;
                s4_ovf_next  = 1'b1;
            end
            else if (sh < sum_t'(WORD_MIN))
            begin
                s4_r_next[r] = WORD_MIN;
                s4_ovf_next  = 1'b1;
            end
            else
            begin
                s4_r_next[r] = word_t'(sh[WORD_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_norm_reg <= s3_norm_reg;
            s4_ovf_reg  <= s4_ovf_next;
            for (int r = 0; r < 4; r++)
            begin
                s4_r_reg[r] <= s4_r_next[r];
            end
        end
    end

    // ---------------- divider setup ----------------
    // magnitudes in, sign applied after the array; trunc toward zero
    div_lane_t prep_lane [3];
    div_ctl_t  prep_ctl;

    always_comb
    begin
        logic [WORD_BITS-1:0] mag;
        logic                 wneg;
        wneg = s4_r_reg[3][WORD_BITS-1];
        prep_ctl.norm = s4_norm_reg;
        prep_ctl.dz   = s4_norm_reg && (s4_r_reg[3] == '0);
        prep_ctl.ovf  = s4_ovf_reg;
        prep_ctl.den  = wneg ? (~s4_r_reg[3] + 1'b1) : s4_r_reg[3];
        for (int r = 0; r < 4; r++)
        begin
            prep_ctl.r[r] = s4_r_reg[r];
        end
        for (int k = 0; k < 3; k++)
        begin
            mag = s4_r_reg[k][WORD_BITS-1] ? (~s4_r_reg[k] + 1'b1) : s4_r_reg[k];
            prep_lane[k].a   = {mag, {FRAC_BITS{1'b0}}};
            prep_lane[k].rem = '0;
            prep_lane[k].neg = s4_r_reg[k][WORD_BITS-1] ^ wneg;
        end
    end

    // ---------------- restoring divider array ----------------
    logic      dv_valid_reg [DIV_STAGES];
    div_lane_t dv_lane_reg  [DIV_STAGES][3];
    div_ctl_t  dv_ctl_reg   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        div_lane_t lane_in   [3];
        div_lane_t lane_next [3];
        div_ctl_t  ctl_in;
        logic      valid_in;

        if (s == 0)
        begin : g_first
            assign valid_in = s4_valid_reg;
            assign ctl_in   = prep_ctl;
            assign lane_in  = prep_lane;
        end
        else
        begin : g_rest
            assign valid_in = dv_valid_reg[s-1];
            assign ctl_in   = dv_ctl_reg[s-1];
            assign lane_in  = dv_lane_reg[s-1];
        end

        always_comb
        begin
            logic [NUM_BITS-1:0]  a;
            logic [WORD_BITS-1:0] rem;
            logic [WORD_BITS:0]   rt;
            for (int k = 0; k < 3; k++)
            begin
                a   = lane_in[k].a;
                rem = lane_in[k].rem;
                for (int j = 0; j < DIV_STEPS; j++)
                begin
                    if (s * DIV_STEPS + j < NUM_BITS)
                    begin
                        rt = {rem, a[NUM_BITS-1]};
                        a  = {a[NUM_BITS-2:0], 1'b0};
                        if (rt >= {1'b0, ctl_in.den})
                        begin
                            rt   = rt - {1'b0, ctl_in.den};
                            a[0] = 1'b1;
                        end
                        rem = rt[WORD_BITS-1:0];
                    end
                end
                lane_next[k].a   = a;
                lane_next[k].rem = rem;
                lane_next[k].neg = lane_in[k].neg;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[s] <= 1'b0;
            else if (adv)
                dv_valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctl_reg[s]  <= ctl_in;
                dv_lane_reg[s] <= lane_next;
            end
        end
    end

    // ---------------- output select and register ----------------
    div_ctl_t last_ctl;
    vtx_out_t rsp_next;
    logic     rsp_valid_reg;
    vtx_out_t rsp_reg;

    assign last_ctl = dv_ctl_reg[DIV_STAGES-1];

    always_comb
    begin
        logic [NUM_BITS-1:0] q;
        word_t               qv [3];
        logic                qovf;
        qovf = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            q = dv_lane_reg[DIV_STAGES-1][k].a;
            if (dv_lane_reg[DIV_STAGES-1][k].neg)
            begin
                if (q > Q_NEG_MAX)
                begin
                    qv[k] = WORD_MIN;
                    qovf  = 1'b1;
                end
                else
                begin
                    qv[k] = word_t'(~q[WORD_BITS-1:0] + 1'b1);
                end
            end
            else
            begin
                if (q > Q_POS_MAX)
                begin
                    qv[k] = WORD_MAX;
                    qovf  = 1'b1;
                end
                else
                begin
                    qv[k] = word_t'(q[WORD_BITS-1:0]);
                end
            end
        end

        if (!last_ctl.norm)
        begin
            rsp_next.rx = IO_BITS'(word_t'(last_ctl.r[0]));
            rsp_next.ry = IO_BITS'(word_t'(last_ctl.r[1]));
            rsp_next.rz = IO_BITS'(word_t'(last_ctl.r[2]));
            rsp_next.rw = IO_BITS'(word_t'(last_ctl.r[3]));
            rsp_next.overflow       = last_ctl.ovf;
            rsp_next.divide_by_zero = 1'b0;
        end
        else if (last_ctl.dz)
        begin
            rsp_next.rx = '0;
            rsp_next.ry = '0;
            rsp_next.rz = '0;
            rsp_next.rw = '0;
            rsp_next.overflow       = 1'b0;
            rsp_next.divide_by_zero = 1'b1;
        end
        else
        begin
            rsp_next.rx = IO_BITS'(qv[0]);
            rsp_next.ry = IO_BITS'(qv[1]);
            rsp_next.rz = IO_BITS'(qv[2]);
            rsp_next.rw = IO_BITS'(ONE_SAT);
            rsp_next.overflow       = last_ctl.ovf | qovf | ONE_OVF;
            rsp_next.divide_by_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= dv_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    a_dz_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |->
            !rsp.overflow && rsp.rx == '0 && rsp.ry == '0 && rsp.rz == '0 && rsp.rw == '0)
        else $error("divide by zero result not cleared");

    a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.opcode == OP_LOAD |=> !s1_valid_reg)
        else $error("load transaction entered the datapath");

    a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.opcode == OP_LOAD |=>
            matrix_reg[$past(req.coeff_index)] ==
                word_t'($past(req.coeff_value[WORD_BITS-1:0])))
        else $error("coefficient write lost");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dv_valid_reg[DIV_STAGES-1]) && $stable(s4_valid_reg))
        else $error("pipeline moved during stall");

endmodule
